### rtl/cfvp_pkg.sv
// ----------------------------------------------------------------------------
// cfvp_pkg
// Shared types and constants of the Coulomb friction velocity projection.
// ----------------------------------------------------------------------------
package cfvp_pkg;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    // tangent components are brought below 2**NORM_BITS before squaring
    localparam int NORM_BITS = 31;

    typedef enum logic [1:0] {
        KIND_SEPARATE = 2'd0,
        KIND_STICK    = 2'd1,
        KIND_SLIP     = 2'd2
    } contact_kind_t;

endpackage

### rtl/cfvp_isqrt.sv
// ----------------------------------------------------------------------------
// cfvp_isqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cfvp_isqrt #(
    parameter int IN_W = 36,
    parameter int PL_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfvp_pkg::pipe_ctl_t  ctl_in,
    input  logic [IN_W-1:0]      rad_in,
    input  logic [PL_W-1:0]      pl_in,
    output logic                 valid_out,
    output logic [IN_W/2-1:0]    root_out,
    output logic [PL_W-1:0]      pl_out
);

    localparam int ST = IN_W / 2;

    logic [IN_W-1:0] x_reg [ST];
    logic [IN_W-1:0] r_reg [ST];
    logic [PL_W-1:0] pl_reg [ST];
    logic [ST-1:0]   vld_reg;
    logic [IN_W-1:0] x_next [ST];
    logic [IN_W-1:0] r_next [ST];

    always_comb begin
        logic [IN_W-1:0] xp;
        logic [IN_W-1:0] rp;
        logic [IN_W-1:0] bitv;
        logic [IN_W-1:0] trial;
        for (int j = 0; j < ST; j++) begin
            xp    = (j == 0) ? rad_in : x_reg[(j == 0) ? 0 : j - 1];
            rp    = (j == 0) ? '0 : r_reg[(j == 0) ? 0 : j - 1];
            bitv  = IN_W'(1) << (IN_W - 2 - 2 * j);
            trial = rp + bitv;
            if (xp >= trial) begin
                x_next[j] = xp - trial;
                r_next[j] = (rp >> 1) + bitv;
            end else begin
                x_next[j] = xp;
                r_next[j] = rp >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl_in.en) begin
            vld_reg <= {vld_reg[ST-2:0], ctl_in.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.en) begin
            for (int j = 0; j < ST; j++) begin
                x_reg[j]  <= x_next[j];
                r_reg[j]  <= r_next[j];
                pl_reg[j] <= (j == 0) ? pl_in : pl_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    assign valid_out = vld_reg[ST-1];
    assign root_out  = r_reg[ST-1][ST-1:0];
    assign pl_out    = pl_reg[ST-1];

endmodule

### rtl/cfvp_div.sv
// ----------------------------------------------------------------------------
// cfvp_div
// Pipelined restoring divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module cfvp_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 40,
    parameter int Q_W   = 17,
    parameter int PL_W  = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfvp_pkg::pipe_ctl_t  ctl_in,
    input  logic [NUM_W-1:0]     num_in,
    input  logic [DEN_W-1:0]     den_in,
    input  logic [PL_W-1:0]      pl_in,
    output logic                 valid_out,
    output logic [Q_W-1:0]       quo_out,
    output logic [PL_W-1:0]      pl_out
);

    localparam int CW = NUM_W + Q_W;

    logic [NUM_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   q_reg [Q_W];
    logic [PL_W-1:0]  pl_reg [Q_W];
    logic [Q_W-1:0]   vld_reg;
    logic [NUM_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   q_next [Q_W];

    always_comb begin
        logic [NUM_W-1:0] rp;
        logic [DEN_W-1:0] dp;
        logic [Q_W-1:0]   qp;
        logic [CW-1:0]    wide;
        logic [CW-1:0]    sub;
        for (int j = 0; j < Q_W; j++) begin
            rp   = (j == 0) ? num_in : rem_reg[(j == 0) ? 0 : j - 1];
            dp   = (j == 0) ? den_in : den_reg[(j == 0) ? 0 : j - 1];
            qp   = (j == 0) ? '0 : q_reg[(j == 0) ? 0 : j - 1];
            wide = CW'(rp);
            sub  = CW'(dp) << (Q_W - 1 - j);
            if (wide >= sub) begin
                wide        = wide - sub;
                rem_next[j] = wide[NUM_W-1:0];
                q_next[j]   = qp | (Q_W'(1) << (Q_W - 1 - j));
            end else begin
                rem_next[j] = rp;
                q_next[j]   = qp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl_in.en) begin
            vld_reg <= {vld_reg[Q_W-2:0], ctl_in.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.en) begin
            for (int j = 0; j < Q_W; j++) begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
                den_reg[j] <= (j == 0) ? den_in : den_reg[(j == 0) ? 0 : j - 1];
                pl_reg[j]  <= (j == 0) ? pl_in : pl_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    assign valid_out = vld_reg[Q_W-1];
    assign quo_out   = q_reg[Q_W-1];
    assign pl_out    = pl_reg[Q_W-1];

endmodule

### rtl/cfvp_front.sv
// ----------------------------------------------------------------------------
// cfvp_front
// Normal speed, normal length squared and tangential velocity, four stages.
// ----------------------------------------------------------------------------
module cfvp_front #(
    parameter int VEL_W  = 32,
    parameter int FRAC_W = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cfvp_pkg::pipe_ctl_t         ctl_in,
    input  logic signed [VEL_W-1:0]     vel_in [3],
    input  logic signed [FRAC_W+1:0]    nrm_in [3],
    output logic                        valid_out,
    output logic signed [VEL_W-1:0]     vel_out [3],
    output logic signed [VEL_W+6:0]     vt_out [3],
    output logic [2*FRAC_W+5:0]         nn_out,
    output logic [VEL_W+3:0]            ad_out,
    output logic                        sep_out
);

    localparam int NW  = FRAC_W + 2;
    localparam int PW  = VEL_W + NW;
    localparam int RW  = PW + 2;
    localparam int DW  = RW - FRAC_W;
    localparam int DNW = DW + NW;
    localparam int NNW = 2 * NW + 2;
    localparam int VTW = VEL_W + 7;

    logic [3:0]              vld_reg;
    logic signed [PW-1:0]    p_reg [3];
    logic [2*NW-1:0]         q_reg [3];
    logic signed [VEL_W-1:0] v1_reg [3];
    logic signed [NW-1:0]    n1_reg [3];

    logic signed [RW-1:0]    raw_next;
    logic [NNW-1:0]          nn_next;
    logic signed [DW-1:0]    d2_reg;
    logic [NNW-1:0]          nn2_reg;
    logic                    sep2_reg;
    logic signed [VEL_W-1:0] v2_reg [3];
    logic signed [NW-1:0]    n2_reg [3];

    logic [DW-1:0]           ad_next;
    logic signed [DNW-1:0]   dn3_reg [3];
    logic [DW-1:0]           ad3_reg;
    logic                    sep3_reg;
    logic [NNW-1:0]          nn3_reg;
    logic signed [VEL_W-1:0] v3_reg [3];

    logic signed [VTW-1:0]   vt_next [3];
    logic signed [VTW-1:0]   vt4_reg [3];
    logic [DW-1:0]           ad4_reg;
    logic                    sep4_reg;
    logic [NNW-1:0]          nn4_reg;
    logic signed [VEL_W-1:0] v4_reg [3];

    always_comb begin
        logic signed [VTW-1:0] ve;
        logic signed [VTW-1:0] de;
        raw_next = RW'(p_reg[0]) + RW'(p_reg[1]) + RW'(p_reg[2]);
        nn_next  = NNW'(q_reg[0]) + NNW'(q_reg[1]) + NNW'(q_reg[2]);
        ad_next  = d2_reg[DW-1] ? DW'(-d2_reg) : DW'(d2_reg);
        for (int i = 0; i < 3; i++) begin
            ve         = VTW'(v3_reg[i]);
            de         = VTW'($signed(dn3_reg[i][DNW-1:FRAC_W]));
            vt_next[i] = ve - de;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl_in.en) begin
            vld_reg <= {vld_reg[2:0], ctl_in.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.en) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[i]   <= vel_in[i] * nrm_in[i];
                q_reg[i]   <= nrm_in[i] * nrm_in[i];
                v1_reg[i]  <= vel_in[i];
                n1_reg[i]  <= nrm_in[i];
                v2_reg[i]  <= v1_reg[i];
                n2_reg[i]  <= n1_reg[i];
                dn3_reg[i] <= d2_reg * n2_reg[i];
                v3_reg[i]  <= v2_reg[i];
                vt4_reg[i] <= vt_next[i];
                v4_reg[i]  <= v3_reg[i];
            end
            d2_reg   <= raw_next[RW-1:FRAC_W];
            nn2_reg  <= nn_next;
            sep2_reg <= (raw_next > 0);
            ad3_reg  <= ad_next;
            sep3_reg <= sep2_reg;
            nn3_reg  <= nn2_reg;
            ad4_reg  <= ad3_reg;
            sep4_reg <= sep3_reg;
            nn4_reg  <= nn3_reg;
        end
    end

    assign valid_out = vld_reg[3];
    assign vel_out   = v4_reg;
    assign vt_out    = vt4_reg;
    assign nn_out    = nn4_reg;
    assign ad_out    = ad4_reg;
    assign sep_out   = sep4_reg;

endmodule

### rtl/coulomb_friction_velocity_projection.sv
// ----------------------------------------------------------------------------
// coulomb_friction_velocity_projection
// Coulomb friction projection of a contact's relative velocity.
// ----------------------------------------------------------------------------
// Input beats on s_* carry a velocity and a contact normal; each gives one
// result beat on m_* with the projected velocity, the contact kind and a
// saturation flag. cfg_* writes the friction coefficient mu (write it while
// the block is idle); cfg_ready is always high.
// The pipeline is four front stages, a FRAC_BITS+3 stage root of |n|^2,
// four stages, a 32 stage root of |vt|^2, two stages, a FRAC_BITS+1 stage
// divider for the slip scale and two output stages. One beat is accepted
// per cycle while the pipeline advances.
// The whole pipeline advances when the output register is empty or taken;
// while m_tready is low and a result waits, s_tready is low and nothing moves.
// Reset clears all valid bits and sets mu to zero.
// ----------------------------------------------------------------------------
module coulomb_friction_velocity_projection #(
    parameter int VEL_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // vel_in_x, vel_in_y, vel_in_z, normal_x, normal_y, normal_z, zero pad
    input  logic [((3*VEL_WIDTH+3*(FRAC_BITS+2)+7)/8)*8-1:0]      s_tdata,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // vel_out_x, vel_out_y, vel_out_z
    output logic [3*VEL_WIDTH-1:0]                                m_tdata,
    // contact_kind, saturated
    output logic [2:0]                                            m_tuser,
    input  logic                                                  cfg_valid,
    output logic                                                  cfg_ready,
    input  logic [FRAC_BITS+3:0]                                  cfg_data
);

    import cfvp_pkg::*;

    localparam int VW    = VEL_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int NW    = F + 2;
    localparam int MW    = F + 4;
    localparam int DW    = VW + 4;
    localparam int VTW   = VW + 7;
    localparam int NNW   = 2 * NW + 2;
    localparam int RNW   = NNW / 2;
    localparam int VNNW  = DW + RNW - F;
    localparam int MVW   = MW + VNNW;
    localparam int SHMAX = (VTW > NORM_BITS) ? VTW - NORM_BITS : 0;
    localparam int SHW   = (SHMAX > 0) ? $clog2(SHMAX + 1) : 1;
    localparam int SQW   = 2 * NORM_BITS + 2;
    localparam int SRW   = SQW / 2;
    localparam int VTNW  = SRW + SHMAX;
    localparam int CMW   = (VTNW + F > MVW) ? VTNW + F : MVW;
    localparam int NUMW  = VTNW + F;
    localparam int QW    = F + 1;
    localparam int PRW   = VTW + QW + 1;
    localparam int SW    = PRW - F;
    localparam int PL1W  = 3 * VW + 3 * VTW + 1 + DW;
    localparam int PL2W  = 3 * VW + 3 * VTW + 1 + SHW + MVW;
    localparam int PL3W  = 3 * VW + 3 * VTW + 2;
    localparam logic signed [SW-1:0] VHI = (SW'(1) <<< (VW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] VLO = -VHI - SW'(1);

    logic          adv;
    logic [MW-1:0] coeff_reg;
    logic [7:0]    stg_vld_reg;

    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
        end else if (cfg_valid) begin
            coeff_reg <= cfg_data;
        end
    end

    // front: dot product, normal split
    logic signed [VW-1:0]  vel_in [3];
    logic signed [NW-1:0]  nrm_in [3];
    logic                  fr_valid;
    logic signed [VW-1:0]  fr_v [3];
    logic signed [VTW-1:0] fr_vt [3];
    logic [NNW-1:0]        fr_nn;
    logic [DW-1:0]         fr_ad;
    logic                  fr_sep;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vel_in[i] = s_tdata[i*VW +: VW];
            nrm_in[i] = s_tdata[3*VW + i*NW +: NW];
        end
    end

    cfvp_front #(
        .VEL_W  (VW),
        .FRAC_W (F)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    ('{en: adv, valid: s_tvalid}),
        .vel_in    (vel_in),
        .nrm_in    (nrm_in),
        .valid_out (fr_valid),
        .vel_out   (fr_v),
        .vt_out    (fr_vt),
        .nn_out    (fr_nn),
        .ad_out    (fr_ad),
        .sep_out   (fr_sep)
    );

    // |n| root
    logic                  q1_valid;
    logic [RNW-1:0]        q1_root;
    logic [PL1W-1:0]       q1_pl;
    logic signed [VW-1:0]  q1_v [3];
    logic signed [VTW-1:0] q1_vt [3];
    logic                  q1_sep;
    logic [DW-1:0]         q1_ad;

    cfvp_isqrt #(
        .IN_W (NNW),
        .PL_W (PL1W)
    ) u_sqrt_nrm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    ('{en: adv, valid: fr_valid}),
        .rad_in    (fr_nn),
        .pl_in     ({fr_v[0], fr_v[1], fr_v[2], fr_vt[0], fr_vt[1], fr_vt[2],
                     fr_sep, fr_ad}),
        .valid_out (q1_valid),
        .root_out  (q1_root),
        .pl_out    (q1_pl)
    );

    assign {q1_v[0], q1_v[1], q1_v[2], q1_vt[0], q1_vt[1], q1_vt[2],
            q1_sep, q1_ad} = q1_pl;

    // stages 1..4: |vn|, mu*|vn|, tangent normalization, sum of squares
    logic [DW+RNW-1:0]     s1_vn_next;
    logic [VTW-1:0]        s1_avt_next [3];
    logic signed [VW-1:0]  s1_v_reg [3];
    logic signed [VTW-1:0] s1_vt_reg [3];
    logic [VTW-1:0]        s1_avt_reg [3];
    logic                  s1_sep_reg;
    logic [VNNW-1:0]       s1_vnn_reg;

    logic [VTW-1:0]        s2_max_next;
    logic [SHW-1:0]        s2_sh_next;
    logic signed [VW-1:0]  s2_v_reg [3];
    logic signed [VTW-1:0] s2_vt_reg [3];
    logic [VTW-1:0]        s2_avt_reg [3];
    logic                  s2_sep_reg;
    logic [MVW-1:0]        s2_muvn_reg;
    logic [SHW-1:0]        s2_sh_reg;

    logic [NORM_BITS-1:0]  s3_t_next [3];
    logic signed [VW-1:0]  s3_v_reg [3];
    logic signed [VTW-1:0] s3_vt_reg [3];
    logic                  s3_sep_reg;
    logic [MVW-1:0]        s3_muvn_reg;
    logic [SHW-1:0]        s3_sh_reg;
    logic [SQW-1:0]        s3_sqr_reg [3];

    logic signed [VW-1:0]  s4_v_reg [3];
    logic signed [VTW-1:0] s4_vt_reg [3];
    logic                  s4_sep_reg;
    logic [MVW-1:0]        s4_muvn_reg;
    logic [SHW-1:0]        s4_sh_reg;
    logic [SQW-1:0]        s4_sq_reg;

    always_comb begin
        s1_vn_next = DW'(q1_ad) * RNW'(q1_root);
        for (int i = 0; i < 3; i++) begin
            s1_avt_next[i] = q1_vt[i][VTW-1] ? VTW'(-q1_vt[i]) : VTW'(q1_vt[i]);
            s3_t_next[i]   = NORM_BITS'(s2_avt_reg[i] >> s2_sh_reg);
        end
        s2_max_next = s1_avt_reg[0];
        if (s1_avt_reg[1] > s2_max_next) begin
            s2_max_next = s1_avt_reg[1];
        end
        if (s1_avt_reg[2] > s2_max_next) begin
            s2_max_next = s1_avt_reg[2];
        end
        s2_sh_next = '0;
        for (int k = 0; k < SHMAX; k++) begin
            if ((s2_max_next >> (NORM_BITS + k)) != '0) begin
                s2_sh_next = SHW'(k + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s1_v_reg[i]   <= q1_v[i];
                s1_vt_reg[i]  <= q1_vt[i];
                s1_avt_reg[i] <= s1_avt_next[i];
                s2_v_reg[i]   <= s1_v_reg[i];
                s2_vt_reg[i]  <= s1_vt_reg[i];
                s2_avt_reg[i] <= s1_avt_reg[i];
                s3_v_reg[i]   <= s2_v_reg[i];
                s3_vt_reg[i]  <= s2_vt_reg[i];
                s3_sqr_reg[i] <= SQW'(s3_t_next[i]) * SQW'(s3_t_next[i]);
                s4_v_reg[i]   <= s3_v_reg[i];
                s4_vt_reg[i]  <= s3_vt_reg[i];
            end
            s1_sep_reg  <= q1_sep;
            s1_vnn_reg  <= s1_vn_next[DW+RNW-1:F];
            s2_sep_reg  <= s1_sep_reg;
            s2_muvn_reg <= MVW'(coeff_reg) * MVW'(s1_vnn_reg);
            s2_sh_reg   <= s2_sh_next;
            s3_sep_reg  <= s2_sep_reg;
            s3_muvn_reg <= s2_muvn_reg;
            s3_sh_reg   <= s2_sh_reg;
            s4_sep_reg  <= s3_sep_reg;
            s4_muvn_reg <= s3_muvn_reg;
            s4_sh_reg   <= s3_sh_reg;
            s4_sq_reg   <= s3_sqr_reg[0] + s3_sqr_reg[1] + s3_sqr_reg[2];
        end
    end

    // |vt| root
    logic                  q2_valid;
    logic [SRW-1:0]        q2_root;
    logic [PL2W-1:0]       q2_pl;
    logic signed [VW-1:0]  q2_v [3];
    logic signed [VTW-1:0] q2_vt [3];
    logic                  q2_sep;
    logic [SHW-1:0]        q2_sh;
    logic [MVW-1:0]        q2_muvn;

    cfvp_isqrt #(
        .IN_W (SQW),
        .PL_W (PL2W)
    ) u_sqrt_tan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    ('{en: adv, valid: stg_vld_reg[3]}),
        .rad_in    (s4_sq_reg),
        .pl_in     ({s4_v_reg[0], s4_v_reg[1], s4_v_reg[2], s4_vt_reg[0],
                     s4_vt_reg[1], s4_vt_reg[2], s4_sep_reg, s4_sh_reg,
                     s4_muvn_reg}),
        .valid_out (q2_valid),
        .root_out  (q2_root),
        .pl_out    (q2_pl)
    );

    assign {q2_v[0], q2_v[1], q2_v[2], q2_vt[0], q2_vt[1], q2_vt[2],
            q2_sep, q2_sh, q2_muvn} = q2_pl;

    // stages 5..6: |vt|, stick test, slip numerator
    logic signed [VW-1:0]  s5_v_reg [3];
    logic signed [VTW-1:0] s5_vt_reg [3];
    logic                  s5_sep_reg;
    logic [MVW-1:0]        s5_muvn_reg;
    logic [VTNW-1:0]       s5_vtn_reg;

    logic                  s6_stick_next;
    logic [CMW-1:0]        s6_diff_next;
    logic signed [VW-1:0]  s6_v_reg [3];
    logic signed [VTW-1:0] s6_vt_reg [3];
    logic                  s6_sep_reg;
    logic                  s6_stick_reg;
    logic [VTNW-1:0]       s6_diff_reg;
    logic [VTNW-1:0]       s6_den_reg;

    always_comb begin
        s6_stick_next = (CMW'({s5_vtn_reg, {F{1'b0}}}) <= CMW'(s5_muvn_reg));
        s6_diff_next  = CMW'(s5_vtn_reg) - CMW'(s5_muvn_reg >> F);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s5_v_reg[i]  <= q2_v[i];
                s5_vt_reg[i] <= q2_vt[i];
                s6_v_reg[i]  <= s5_v_reg[i];
                s6_vt_reg[i] <= s5_vt_reg[i];
            end
            s5_sep_reg   <= q2_sep;
            s5_muvn_reg  <= q2_muvn;
            s5_vtn_reg   <= VTNW'(q2_root) << q2_sh;
            s6_sep_reg   <= s5_sep_reg;
            s6_stick_reg <= s6_stick_next;
            s6_diff_reg  <= s6_diff_next[VTNW-1:0];
            s6_den_reg   <= s5_vtn_reg;
        end
    end

    // slip scale
    logic                  dv_valid;
    logic [QW-1:0]         dv_quo;
    logic [PL3W-1:0]       dv_pl;
    logic signed [VW-1:0]  dv_v [3];
    logic signed [VTW-1:0] dv_vt [3];
    logic                  dv_sep;
    logic                  dv_stick;

    cfvp_div #(
        .NUM_W (NUMW),
        .DEN_W (VTNW),
        .Q_W   (QW),
        .PL_W  (PL3W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    ('{en: adv, valid: stg_vld_reg[5]}),
        .num_in    ({s6_diff_reg, {F{1'b0}}}),
        .den_in    (s6_den_reg),
        .pl_in     ({s6_v_reg[0], s6_v_reg[1], s6_v_reg[2], s6_vt_reg[0],
                     s6_vt_reg[1], s6_vt_reg[2], s6_sep_reg, s6_stick_reg}),
        .valid_out (dv_valid),
        .quo_out   (dv_quo),
        .pl_out    (dv_pl)
    );

    assign {dv_v[0], dv_v[1], dv_v[2], dv_vt[0], dv_vt[1], dv_vt[2],
            dv_sep, dv_stick} = dv_pl;

    // stages 7..8: scaled tangent, select and clamp
    logic signed [QW:0]    s7_scale;
    logic signed [VW-1:0]  s7_v_reg [3];
    logic                  s7_sep_reg;
    logic                  s7_stick_reg;
    logic signed [PRW-1:0] s7_prod_reg [3];

    logic [3*VW-1:0]       out_data_next;
    logic                  out_sat_next;
    contact_kind_t         out_kind_next;
    logic [3*VW-1:0]       out_data_reg;
    logic                  out_sat_reg;
    contact_kind_t         out_kind_reg;

    assign s7_scale = $signed({1'b0, dv_quo});

    always_comb begin
        logic signed [SW-1:0] scaled;
        logic signed [VW-1:0] res;
        out_sat_next  = 1'b0;
        out_data_next = '0;
        if (s7_sep_reg) begin
            out_kind_next = KIND_SEPARATE;
        end else if (s7_stick_reg) begin
            out_kind_next = KIND_STICK;
        end else begin
            out_kind_next = KIND_SLIP;
        end
        for (int i = 0; i < 3; i++) begin
            scaled = s7_prod_reg[i][PRW-1:F];
            if (scaled > VHI) begin
                res          = VHI[VW-1:0];
                out_sat_next = out_sat_next | !s7_sep_reg & !s7_stick_reg;
            end else if (scaled < VLO) begin
                res          = VLO[VW-1:0];
                out_sat_next = out_sat_next | !s7_sep_reg & !s7_stick_reg;
            end else begin
                res = scaled[VW-1:0];
            end
            if (s7_sep_reg) begin
                res = s7_v_reg[i];
            end else if (s7_stick_reg) begin
                res = '0;
            end
            out_data_next[i*VW +: VW] = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                s7_v_reg[i]    <= dv_v[i];
                s7_prod_reg[i] <= dv_vt[i] * s7_scale;
            end
            s7_sep_reg   <= dv_sep;
            s7_stick_reg <= dv_stick;
            out_data_reg <= out_data_next;
            out_sat_reg  <= out_sat_next;
            out_kind_reg <= out_kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg <= '0;
        end else if (adv) begin
            stg_vld_reg <= {stg_vld_reg[6], dv_valid, stg_vld_reg[4], q2_valid,
                            stg_vld_reg[2:0], q1_valid};
        end
    end

    assign m_tvalid = stg_vld_reg[7];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_sat_reg, out_kind_reg};

endmodule
